// ===== hdl/assert_macros.svh =====
// assertion macros included by kvtt_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define KVTT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kvtt_pkg.sv =====
// types, codes and character constants of the key/value tokenizer
package kvtt_pkg;

    localparam int PENDING_BLANK_DEPTH_DEF = 32;
    localparam int LINE_BITS_DEF           = 20;
    localparam int COLUMN_BITS_DEF         = 16;

    // result kinds
    localparam logic [2:0] EV_KEY  = 3'd0;
    localparam logic [2:0] EV_VAL  = 3'd1;
    localparam logic [2:0] EV_PAIR = 3'd2;
    localparam logic [2:0] EV_OK   = 3'd3;
    localparam logic [2:0] EV_ERR  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_EOL      = 3'd1;
    localparam logic [2:0] ERR_EQUALS   = 3'd2;
    localparam logic [2:0] ERR_END      = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    typedef enum logic [3:0] {
        PH_LINE        = 4'd0,
        PH_KEY         = 4'd1,
        PH_AFTER_KEY   = 4'd2,
        PH_BEFORE_VAL  = 4'd3,
        PH_LT          = 4'd4,
        PH_SINGLE      = 4'd5,
        PH_MULTI       = 4'd6,
        PH_MULTI_Q     = 4'd7,
        PH_AFTER_MULTI = 4'd8,
        PH_COMMENT     = 4'd9,
        PH_HALT        = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_PRE   = 2'd1,
        ST_BLANK = 2'd2,
        ST_MAIN  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic load_pre;
        logic load_blank;
        logic load_main;
    } dp_cmd_t;

    typedef struct packed {
        logic dec_pre;
        logic dec_flush;
        logic dec_main;
        logic plan_flush;
        logic plan_main;
        logic blank_last;
    } dp_status_t;

endpackage

// ===== hdl/kvtt_datapath.sv =====
// parser state, item decode, result plan and output register
module kvtt_datapath
    import kvtt_pkg::*;
#(
    parameter int PENDING_BLANK_DEPTH = PENDING_BLANK_DEPTH_DEF,
    parameter int LINE_BITS           = LINE_BITS_DEF,
    parameter int COLUMN_BITS         = COLUMN_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic [2:0]             event_kind,
    output logic [7:0]             event_byte,
    output logic [2:0]             error_code,
    output logic [LINE_BITS-1:0]   line_number,
    output logic [COLUMN_BITS-1:0] column_number,
    output logic                   last_of_run
);

    localparam int CNT_W = $clog2(PENDING_BLANK_DEPTH + 1);
    localparam int IDX_W = (PENDING_BLANK_DEPTH > 1) ? $clog2(PENDING_BLANK_DEPTH) : 1;
    localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_TOP  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    // parser state
    phase_t                         phase_reg;
    logic [LINE_BITS-1:0]           line_reg;
    logic [COLUMN_BITS-1:0]         col_reg;
    logic [PENDING_BLANK_DEPTH-1:0] kinds_reg;
    logic [CNT_W-1:0]               count_reg;

    // plan of the accepted item
    logic [7:0]                     pre_byte_reg;
    logic                           plan_flush_reg;
    logic                           plan_main_reg;
    logic [PENDING_BLANK_DEPTH-1:0] flush_kinds_reg;
    logic [CNT_W-1:0]               flush_cnt_reg;
    logic [IDX_W-1:0]               blank_idx_reg;
    logic [2:0]                     main_kind_reg;
    logic [7:0]                     main_byte_reg;
    logic [2:0]                     main_code_reg;
    logic [LINE_BITS-1:0]           main_line_reg;
    logic [COLUMN_BITS-1:0]         main_col_reg;

    // output register
    logic [2:0]             out_kind_reg;
    logic [7:0]             out_byte_reg;
    logic [2:0]             out_code_reg;
    logic [LINE_BITS-1:0]   out_line_reg;
    logic [COLUMN_BITS-1:0] out_col_reg;
    logic                   out_last_reg;

    // decode results
    phase_t                         d_phase;
    logic [LINE_BITS-1:0]           d_line;
    logic [COLUMN_BITS-1:0]         d_col;
    logic [PENDING_BLANK_DEPTH-1:0] d_kinds;
    logic [CNT_W-1:0]               d_count;
    logic                           d_pre;
    logic [7:0]                     d_pre_byte;
    logic                           d_flush;
    logic                           d_main;
    logic [2:0]                     d_kind;
    logic [7:0]                     d_byte;
    logic [2:0]                     d_code;
    logic [LINE_BITS-1:0]           d_err_line;
    logic [COLUMN_BITS-1:0]         d_err_col;

    logic                   at_end;
    logic                   is_blank;
    logic                   is_key;
    logic                   do_single;
    logic                   do_multi;
    logic [LINE_BITS-1:0]   line_inc;
    logic [COLUMN_BITS-1:0] col_inc1;
    logic [COLUMN_BITS-1:0] col_inc2;
    logic [COLUMN_BITS-1:0] sb_base;
    logic [COLUMN_BITS-1:0] sb_inc;
    logic [COLUMN_BITS-1:0] mb_base;
    logic [COLUMN_BITS-1:0] mb_inc;

    assign at_end   = end_of_text || (text_byte == CH_NUL);
    assign is_blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
    assign is_key   = (text_byte == CH_MINUS) || (text_byte == CH_UNDER)
                   || ((text_byte >= CH_0) && (text_byte <= CH_9))
                   || ((text_byte >= CH_UC_A) && (text_byte <= CH_UC_Z))
                   || ((text_byte >= CH_LC_A) && (text_byte <= CH_LC_Z));

    assign line_inc = (line_reg == LINE_TOP) ? line_reg : line_reg + LINE_ONE;
    assign col_inc1 = (col_reg == COL_TOP) ? col_reg : col_reg + COL_ONE;
    assign col_inc2 = (col_inc1 == COL_TOP) ? col_inc1 : col_inc1 + COL_ONE;

    // a held '<' or '?' has not yet moved the column on, so the bases add one for it
    assign sb_base = (phase_reg == PH_LT) ? col_inc1 : col_reg;
    assign sb_inc  = (phase_reg == PH_LT) ? col_inc2 : col_inc1;
    assign mb_base = (phase_reg == PH_MULTI_Q) ? col_inc1 : col_reg;
    assign mb_inc  = (phase_reg == PH_MULTI_Q) ? col_inc2 : col_inc1;

    always_comb begin
        d_phase    = phase_reg;
        d_line     = line_reg;
        d_col      = col_reg;
        d_kinds    = kinds_reg;
        d_count    = count_reg;
        d_pre      = 1'b0;
        d_pre_byte = CH_LT;
        d_flush    = 1'b0;
        d_main     = 1'b0;
        d_kind     = EV_KEY;
        d_byte     = text_byte;
        d_code     = ERR_NONE;
        d_err_line = '0;
        d_err_col  = '0;
        do_single  = 1'b0;
        do_multi   = 1'b0;

        if (at_end) begin
            d_phase = PH_LINE;
            d_line  = LINE_ONE;
            d_col   = COL_ONE;
            d_kinds = '0;
            d_count = '0;
            d_byte  = CH_NUL;
            case (phase_reg)
                PH_LINE: begin
                    d_main = 1'b1;
                    d_kind = EV_OK;
                end
                PH_KEY, PH_AFTER_KEY: begin
                    d_main     = 1'b1;
                    d_kind     = EV_ERR;
                    d_code     = ERR_EQUALS;
                    d_err_line = line_reg;
                    d_err_col  = col_reg;
                end
                PH_LT, PH_MULTI_Q: begin
                    d_pre      = 1'b1;
                    d_pre_byte = (phase_reg == PH_LT) ? CH_LT : CH_QUEST;
                    d_main     = 1'b1;
                    d_kind     = EV_ERR;
                    d_code     = ERR_END;
                    d_err_line = line_reg;
                    d_err_col  = col_inc1;
                end
                PH_AFTER_MULTI: begin
                    d_main     = 1'b1;
                    d_kind     = EV_ERR;
                    d_code     = ERR_EOL;
                    d_err_line = line_reg;
                    d_err_col  = col_reg;
                end
                PH_BEFORE_VAL, PH_SINGLE, PH_MULTI, PH_COMMENT: begin
                    d_main     = 1'b1;
                    d_kind     = EV_ERR;
                    d_code     = ERR_END;
                    d_err_line = line_reg;
                    d_err_col  = col_reg;
                end
                default: begin
                end
            endcase
        end else begin
            case (phase_reg)
                PH_LINE, PH_AFTER_MULTI: begin
                    if (is_blank) begin
                        d_col = col_inc1;
                    end else if (is_key && (phase_reg == PH_LINE)) begin
                        d_main  = 1'b1;
                        d_kind  = EV_KEY;
                        d_col   = col_inc1;
                        d_phase = PH_KEY;
                    end else if (text_byte == CH_HASH) begin
                        d_col   = col_inc1;
                        d_phase = PH_COMMENT;
                    end else if (text_byte == CH_NL) begin
                        d_line  = line_inc;
                        d_col   = COL_ONE;
                        d_phase = PH_LINE;
                    end else begin
                        d_main     = 1'b1;
                        d_kind     = EV_ERR;
                        d_code     = ERR_EOL;
                        d_err_line = line_reg;
                        d_err_col  = col_reg;
                        d_phase    = PH_HALT;
                    end
                end
                PH_KEY, PH_AFTER_KEY: begin
                    if ((phase_reg == PH_KEY) && is_key) begin
                        d_main = 1'b1;
                        d_kind = EV_KEY;
                        d_col  = col_inc1;
                    end else if (is_blank) begin
                        d_col   = col_inc1;
                        d_phase = PH_AFTER_KEY;
                    end else if (text_byte == CH_EQ) begin
                        d_col   = col_inc1;
                        d_phase = PH_BEFORE_VAL;
                    end else begin
                        d_main     = 1'b1;
                        d_kind     = EV_ERR;
                        d_code     = ERR_EQUALS;
                        d_err_line = line_reg;
                        d_err_col  = col_reg;
                        d_phase    = PH_HALT;
                    end
                end
                PH_BEFORE_VAL: begin
                    if (is_blank) begin
                        d_col = col_inc1;
                    end else if (text_byte == CH_LT) begin
                        d_phase = PH_LT;
                    end else begin
                        do_single = 1'b1;
                    end
                end
                PH_LT: begin
                    if (text_byte == CH_QUEST) begin
                        d_col   = col_inc2;
                        d_phase = PH_MULTI;
                    end else begin
                        d_pre      = 1'b1;
                        d_pre_byte = CH_LT;
                        do_single  = 1'b1;
                    end
                end
                PH_SINGLE: begin
                    do_single = 1'b1;
                end
                PH_MULTI: begin
                    do_multi = 1'b1;
                end
                PH_MULTI_Q: begin
                    if (text_byte == CH_GT) begin
                        d_col   = col_inc2;
                        d_main  = 1'b1;
                        d_kind  = EV_PAIR;
                        d_byte  = CH_NUL;
                        d_phase = PH_AFTER_MULTI;
                    end else begin
                        d_pre      = 1'b1;
                        d_pre_byte = CH_QUEST;
                        do_multi   = 1'b1;
                    end
                end
                PH_COMMENT: begin
                    if (text_byte == CH_NL) begin
                        d_line  = line_inc;
                        d_col   = COL_ONE;
                        d_phase = PH_LINE;
                    end else begin
                        d_col = col_inc1;
                    end
                end
                default: begin
                    d_phase = PH_HALT;
                end
            endcase

            // byte of a single-line value
            if (do_single) begin
                d_phase = PH_SINGLE;
                if (text_byte == CH_NL) begin
                    d_kinds = '0;
                    d_count = '0;
                    d_main  = 1'b1;
                    d_kind  = EV_PAIR;
                    d_byte  = CH_NUL;
                    d_line  = line_inc;
                    d_col   = COL_ONE;
                    d_phase = PH_LINE;
                end else if (text_byte == CH_HASH) begin
                    d_kinds = '0;
                    d_count = '0;
                    d_main  = 1'b1;
                    d_kind  = EV_PAIR;
                    d_byte  = CH_NUL;
                    d_col   = sb_inc;
                    d_phase = PH_COMMENT;
                end else if (is_blank) begin
                    if (count_reg >= CNT_W'(PENDING_BLANK_DEPTH)) begin
                        d_main     = 1'b1;
                        d_kind     = EV_ERR;
                        d_code     = ERR_OVERFLOW;
                        d_err_line = line_reg;
                        d_err_col  = sb_base;
                        d_phase    = PH_HALT;
                    end else begin
                        d_kinds[count_reg[IDX_W-1:0]] = (text_byte == CH_TAB);
                        d_count = count_reg + CNT_W'(1);
                        d_col   = sb_inc;
                    end
                end else begin
                    // held blanks go out ahead of this byte
                    d_flush = (count_reg != '0);
                    d_kinds = '0;
                    d_count = '0;
                    d_main  = 1'b1;
                    d_kind  = EV_VAL;
                    d_col   = sb_inc;
                end
            end

            // byte of a multi-line value
            if (do_multi) begin
                if (text_byte == CH_QUEST) begin
                    d_col   = mb_base;
                    d_phase = PH_MULTI_Q;
                end else if (text_byte == CH_NL) begin
                    d_main  = 1'b1;
                    d_kind  = EV_VAL;
                    d_line  = line_inc;
                    d_col   = COL_ONE;
                    d_phase = PH_MULTI;
                end else begin
                    d_main  = 1'b1;
                    d_kind  = EV_VAL;
                    d_col   = mb_inc;
                    d_phase = PH_MULTI;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LINE;
            line_reg       <= LINE_ONE;
            col_reg        <= COL_ONE;
            kinds_reg      <= '0;
            count_reg      <= '0;
            plan_flush_reg <= 1'b0;
            plan_main_reg  <= 1'b0;
            blank_idx_reg  <= '0;
        end else begin
            if (cmd.take) begin
                phase_reg      <= d_phase;
                line_reg       <= d_line;
                col_reg        <= d_col;
                kinds_reg      <= d_kinds;
                count_reg      <= d_count;
                plan_flush_reg <= d_flush;
                plan_main_reg  <= d_main;
                blank_idx_reg  <= '0;
            end else if (cmd.load_blank) begin
                blank_idx_reg <= blank_idx_reg + IDX_W'(1);
            end
        end
    end

    // plan payload, taken with the item
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pre_byte_reg    <= d_pre_byte;
            flush_kinds_reg <= kinds_reg;
            flush_cnt_reg   <= count_reg;
            main_kind_reg   <= d_kind;
            main_byte_reg   <= d_byte;
            main_code_reg   <= d_code;
            main_line_reg   <= d_err_line;
            main_col_reg    <= d_err_col;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_pre) begin
            out_kind_reg <= EV_VAL;
            out_byte_reg <= pre_byte_reg;
            out_code_reg <= ERR_NONE;
            out_line_reg <= '0;
            out_col_reg  <= '0;
            out_last_reg <= !plan_flush_reg && !plan_main_reg;
        end else if (cmd.load_blank) begin
            out_kind_reg <= EV_VAL;
            out_byte_reg <= flush_kinds_reg[blank_idx_reg] ? CH_TAB : CH_SPACE;
            out_code_reg <= ERR_NONE;
            out_line_reg <= '0;
            out_col_reg  <= '0;
            out_last_reg <= 1'b0;
        end else if (cmd.load_main) begin
            out_kind_reg <= main_kind_reg;
            out_byte_reg <= main_byte_reg;
            out_code_reg <= main_code_reg;
            out_line_reg <= main_line_reg;
            out_col_reg  <= main_col_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign status.dec_pre    = d_pre;
    assign status.dec_flush  = d_flush;
    assign status.dec_main   = d_main;
    assign status.plan_flush = plan_flush_reg;
    assign status.plan_main  = plan_main_reg;
    assign status.blank_last = ((CNT_W'(blank_idx_reg) + CNT_W'(1)) == flush_cnt_reg);

    assign event_kind    = out_kind_reg;
    assign event_byte    = out_byte_reg;
    assign error_code    = out_code_reg;
    assign line_number   = out_line_reg;
    assign column_number = out_col_reg;
    assign last_of_run   = out_last_reg;

endmodule

// ===== hdl/kvtt_ctrl.sv =====
// sequencer: takes items and steps each one's results into the output register
module kvtt_ctrl
    import kvtt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

`include "assert_macros.svh"

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t dispatch;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    // first result of a freshly taken item
    always_comb begin
        if (status.dec_pre) begin
            dispatch = ST_PRE;
        end else if (status.dec_flush) begin
            dispatch = ST_BLANK;
        end else if (status.dec_main) begin
            dispatch = ST_MAIN;
        end else begin
            dispatch = ST_IDLE;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = dispatch;
                end
            end
            ST_PRE: begin
                if (out_free) begin
                    cmd.load_pre = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.plan_flush) begin
                        state_next = ST_BLANK;
                    end else if (status.plan_main) begin
                        state_next = ST_MAIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BLANK: begin
                if (out_free) begin
                    cmd.load_blank = 1'b1;
                    m_valid_next   = 1'b1;
                    if (status.blank_last) begin
                        state_next = ST_MAIN;
                    end
                end
            end
            ST_MAIN: begin
                // the next item may be taken while the final result goes out
                if (out_free) begin
                    cmd.load_main = 1'b1;
                    m_valid_next  = 1'b1;
                    s_ready       = 1'b1;
                    state_next    = ST_IDLE;
                    if (s_valid) begin
                        cmd.take   = 1'b1;
                        state_next = dispatch;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `KVTT_ASSERT_IMPL(a_no_take_mid_run, s_valid && s_ready,
        !(state_reg == ST_PRE || state_reg == ST_BLANK), "item taken during a result run")
    `KVTT_ASSERT_IMPL(a_flush_has_byte, state_reg == ST_BLANK, status.plan_main,
        "blank flush without a following value byte")
    `KVTT_ASSERT_NEXT(a_main_waits, state_reg == ST_MAIN && !out_free,
        state_reg == ST_MAIN, "final result dropped while output stalled")

endmodule

// ===== hdl/key_value_text_tokenizer.sv =====
// top level of the key/value text tokenizer
//
// One text byte (or an end marker) is taken per transfer on the s_ side, and the
// results it causes leave one per cycle while m_ready is high through an output
// register on the m_ side, so a plain text stream runs at one byte per cycle
// while m_ready stays high. The next item is taken in the cycle the final
// result of the last one enters the output register; after an item whose only
// result is a held '<' or '?' the sequencer returns to idle first. The longest
// runs come from a value byte that follows held blanks: the blank store of
// PENDING_BLANK_DEPTH entries is replayed one blank per cycle ahead of the
// byte, up to PENDING_BLANK_DEPTH + 1 results. After a syntax error all bytes
// are dropped until the end marker, which restarts the parser.
module key_value_text_tokenizer
    import kvtt_pkg::*;
#(
    parameter int PENDING_BLANK_DEPTH = PENDING_BLANK_DEPTH_DEF,
    parameter int LINE_BITS           = LINE_BITS_DEF,
    parameter int COLUMN_BITS         = COLUMN_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_text_byte,
    input  logic                   s_end_of_text,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_event_kind,
    output logic [7:0]             m_event_byte,
    output logic [2:0]             m_error_code,
    output logic [LINE_BITS-1:0]   m_line_number,
    output logic [COLUMN_BITS-1:0] m_column_number,
    output logic                   m_last_of_run
);

    dp_cmd_t    cmd;
    dp_status_t status;

    kvtt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kvtt_datapath #(
        .PENDING_BLANK_DEPTH (PENDING_BLANK_DEPTH),
        .LINE_BITS           (LINE_BITS),
        .COLUMN_BITS         (COLUMN_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .text_byte     (s_text_byte),
        .end_of_text   (s_end_of_text),
        .cmd           (cmd),
        .status        (status),
        .event_kind    (m_event_kind),
        .event_byte    (m_event_byte),
        .error_code    (m_error_code),
        .line_number   (m_line_number),
        .column_number (m_column_number),
        .last_of_run   (m_last_of_run)
    );

endmodule
